FILE: rtl/core/qpn_pkg.sv
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared widths, types and helpers for the quaternion product normalizer.
// ----------------------------------------------------------------------------
package qpn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int FIX_W     = 18;
    localparam int TOL_W     = 16;
    localparam int PROD_W    = 2 * FIX_W;
    localparam int RAW_W     = PROD_W + 2;
    localparam int P_W       = RAW_W - FRAC_BITS;
    localparam int SQ_W      = 2 * P_W - 3;
    localparam int SUM_W     = SQ_W + 2;
    localparam int RAD_W     = SUM_W + 1;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int NUM_W     = P_W + Q_W;

    // register levels: product lane, merge, square root, divider
    localparam int PROD_LAT  = 2;
    localparam int MERGE_LAT = 2;
    localparam int DIV_LAT   = Q_W + 2;
    localparam int LAT       = PROD_LAT + MERGE_LAT + ROOT_W + DIV_LAT;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

    typedef logic signed [FIX_W-1:0] t_fix;
    typedef logic signed [P_W-1:0]   t_p;

    localparam t_fix FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam t_fix FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

    // saturate a rounded component to the output range
    function automatic t_fix sat_fix(input t_p v);
        t_fix res;
        if (v > P_W'(FIX_MAX)) begin
            res = FIX_MAX;
        end else if (v < P_W'(FIX_MIN)) begin
            res = FIX_MIN;
        end else begin
            res = v[FIX_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/qpn_prod_lane.sv
// ----------------------------------------------------------------------------
// qpn_prod_lane
// One component of the Hamilton product: four multiplies, signed sum, round.
// ----------------------------------------------------------------------------
module qpn_prod_lane import qpn_pkg::*; #(
    parameter logic [LANES-1:0] NEG_MASK = '0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_fix i_a [LANES],
    input  t_fix i_b [LANES],
    output t_p   o_p
);

    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [RAW_W-1:0]  w_raw;
    t_p                       r_p;

    // multiply each term pair
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_prod[k] <= PROD_W'(i_a[k]) * PROD_W'(i_b[k]);
            end
        end
    end

    // add the terms with their signs, then round half up
    always_comb begin
        w_raw = RAW_W'(1) <<< (FRAC_BITS - 1);
        for (int k = 0; k < LANES; k++) begin
            if (NEG_MASK[k]) begin
                w_raw = w_raw - RAW_W'(r_prod[k]);
            end else begin
                w_raw = w_raw + RAW_W'(r_prod[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_raw[RAW_W-1:FRAC_BITS];
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/qpn_merge.sv
// ----------------------------------------------------------------------------
// qpn_merge
// Combine the lanes: sum of squares and the skip decision against tolerance.
// ----------------------------------------------------------------------------
module qpn_merge import qpn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_p               i_p [LANES],
    input  logic [TOL_W-1:0] i_tol,
    output t_p               o_p [LANES],
    output logic [SUM_W-1:0] o_sum,
    output logic             o_bypass
);

    logic signed [2*P_W-1:0] w_sq [LANES];
    logic [SQ_W-1:0]         r_sq [LANES];
    t_p                      r_p3 [LANES];
    t_p                      r_p4 [LANES];
    logic [SUM_W-1:0]        w_sum;
    logic [SUM_W-1:0]        w_one;
    logic [SUM_W-1:0]        w_tol;
    logic [SUM_W-1:0]        w_diff;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_bypass;

    // square each component
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_sq[k] = (2*P_W)'(i_p[k]) * (2*P_W)'(i_p[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_sq[k] <= w_sq[k][SQ_W-1:0];
                r_p3[k] <= i_p[k];
            end
        end
    end

    // sum the squares and measure the distance from one
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            w_sum = w_sum + SUM_W'(r_sq[k]);
        end
        w_one  = SUM_W'(1) << (2 * FRAC_BITS);
        w_tol  = SUM_W'(i_tol) << (2 * FRAC_BITS - TOL_W);
        w_diff = (w_sum > w_one) ? (w_sum - w_one) : (w_one - w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum    <= w_sum;
            r_bypass <= (w_diff < w_tol) || (w_sum == '0);
            r_p4     <= r_p3;
        end
    end

    assign o_p      = r_p4;
    assign o_sum    = r_sum;
    assign o_bypass = r_bypass;

endmodule

FILE: rtl/core/qpn_sqrt.sv
// ----------------------------------------------------------------------------
// qpn_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qpn_sqrt import qpn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_sum,
    output logic [ROOT_W-1:0] o_root
);

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [RAD_W-1:0]  n_rad  [ROOT_W];

    // bring down two radicand bits and try the next root bit
    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = RAD_W'(i_sum);
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial = (REM_W+2)'({root_in, 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = REM_W'(cur - trial);
                n_root[k] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[REM_W-1:0];
                n_root[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            n_rad[k] = rad_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

FILE: rtl/core/qpn_div_lane.sv
// ----------------------------------------------------------------------------
// qpn_div_lane
// Divide one component by the magnitude, rounded to nearest, one quotient
// bit per stage; select the pass-through value when renormalization is off.
// ----------------------------------------------------------------------------
module qpn_div_lane import qpn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_p                i_p,
    input  logic [ROOT_W-1:0] i_mag,
    input  logic              i_bypass,
    output t_fix              o_comp,
    output logic              o_renorm
);

    logic [NUM_W-1:0] w_num;
    logic [P_W-2:0]   w_abs;
    logic [NUM_W-1:0] r_rem  [Q_W+1];
    logic [DEN_W-1:0] r_den  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];
    logic             r_neg  [Q_W+1];
    logic             r_byp  [Q_W+1];
    t_fix             r_pass [Q_W+1];
    logic [NUM_W-1:0] n_rem  [Q_W];
    logic [Q_W-1:0]   n_q    [Q_W];
    t_fix             w_val;
    t_fix             r_comp;
    logic             r_renorm;

    // set up numerator 2*|p|*2^F + mag and denominator 2*mag
    always_comb begin
        w_abs = i_p[P_W-1] ? (P_W-1)'(-i_p) : i_p[P_W-2:0];
        w_num = (NUM_W'(w_abs) << Q_W) + NUM_W'(i_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num;
            r_den[0]  <= {i_mag, 1'b0};
            r_q[0]    <= '0;
            r_neg[0]  <= i_p[P_W-1];
            r_byp[0]  <= i_bypass;
            r_pass[0] <= sat_fix(i_p);
        end
    end

    // restoring division steps, most significant quotient bit first
    always_comb begin
        logic [NUM_W-1:0] dsh;
        for (int j = 0; j < Q_W; j++) begin
            dsh = NUM_W'(r_den[j]) << (Q_W - 1 - j);
            if (r_rem[j] >= dsh) begin
                n_rem[j] = r_rem[j] - dsh;
                n_q[j]   = {r_q[j][Q_W-2:0], 1'b1};
            end else begin
                n_rem[j] = r_rem[j];
                n_q[j]   = {r_q[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_den[j+1]  <= r_den[j];
                r_q[j+1]    <= n_q[j];
                r_neg[j+1]  <= r_neg[j];
                r_byp[j+1]  <= r_byp[j];
                r_pass[j+1] <= r_pass[j];
            end
        end
    end

    // apply the sign; the quotient never exceeds one in Q1.16
    always_comb begin
        if (r_neg[Q_W]) begin
            w_val = -FIX_W'(r_q[Q_W]);
        end else begin
            w_val = FIX_W'(r_q[Q_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_comp   <= r_byp[Q_W] ? r_pass[Q_W] : w_val;
            r_renorm <= !r_byp[Q_W];
        end
    end

    assign o_comp   = r_comp;
    assign o_renorm = r_renorm;

endmodule

FILE: rtl/core/quaternion_product_normalize.sv
// ----------------------------------------------------------------------------
// quaternion_product_normalize
// Hamilton product of two Q1.16 quaternions with conditional renormalization.
// ----------------------------------------------------------------------------
// Takes one quaternion pair per clock and returns one result per clock
// while the output is not stalled. Four lanes each form one product
// component and later divide it by the magnitude; the sum-of-squares merge
// stage and the bit-per-stage square root sit between them. A stall at
// the output freezes the whole pipeline; the input is taken whenever the
// output register is empty or being read. Write the tolerance only while
// no item is in flight.
module quaternion_product_normalize import qpn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_fix             i_left_w,
    input  t_fix             i_left_x,
    input  t_fix             i_left_y,
    input  t_fix             i_left_z,
    input  t_fix             i_right_w,
    input  t_fix             i_right_x,
    input  t_fix             i_right_y,
    input  t_fix             i_right_z,
    output logic             o_valid,
    input  logic             i_ready,
    output t_fix             o_prod_w,
    output t_fix             o_prod_x,
    output t_fix             o_prod_y,
    output t_fix             o_prod_z,
    output logic             o_was_renormalized
);

    logic [TOL_W-1:0]  r_unit_tolerance;
    logic [LAT-1:0]    r_vld;
    logic              w_adv;
    t_fix              w_a [LANES];
    t_fix              w_bw [LANES];
    t_fix              w_bx [LANES];
    t_fix              w_by [LANES];
    t_fix              w_bz [LANES];
    t_p                w_p [LANES];
    t_p                w_pm [LANES];
    logic [SUM_W-1:0]  w_sum;
    logic              w_bypass;
    logic [ROOT_W-1:0] w_mag;
    t_p                r_dp [ROOT_W][LANES];
    logic [ROOT_W-1:0] r_dbyp;
    t_fix              w_comp [LANES];
    logic              w_renorm [LANES];

    // advance when the output register is free or being drained
    assign w_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[LAT-1];

    // hold the tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_tolerance <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_unit_tolerance <= i_cfg_data;
        end
    end

    // track which stages hold an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // route term operands to each lane
    assign w_a  = '{i_left_w, i_left_x, i_left_y, i_left_z};
    assign w_bw = '{i_right_w, i_right_x, i_right_y, i_right_z};
    assign w_bx = '{i_right_x, i_right_w, i_right_z, i_right_y};
    assign w_by = '{i_right_y, i_right_z, i_right_w, i_right_x};
    assign w_bz = '{i_right_z, i_right_y, i_right_x, i_right_w};

    qpn_prod_lane #(.NEG_MASK(4'b1110)) u_lane_w (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_a), .i_b(w_bw), .o_p(w_p[0])
    );
    qpn_prod_lane #(.NEG_MASK(4'b1000)) u_lane_x (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_a), .i_b(w_bx), .o_p(w_p[1])
    );
    qpn_prod_lane #(.NEG_MASK(4'b0010)) u_lane_y (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_a), .i_b(w_by), .o_p(w_p[2])
    );
    qpn_prod_lane #(.NEG_MASK(4'b0100)) u_lane_z (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_a), .i_b(w_bz), .o_p(w_p[3])
    );

    qpn_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_p      (w_p),
        .i_tol    (r_unit_tolerance),
        .o_p      (w_pm),
        .o_sum    (w_sum),
        .o_bypass (w_bypass)
    );

    qpn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sum  (w_sum),
        .o_root (w_mag)
    );

    // delay components and decision alongside the square root
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dp[0] <= w_pm;
            for (int k = 1; k < ROOT_W; k++) begin
                r_dp[k] <= r_dp[k-1];
            end
            r_dbyp <= {r_dbyp[ROOT_W-2:0], w_bypass};
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_div
        qpn_div_lane u_div (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_p      (r_dp[ROOT_W-1][g]),
            .i_mag    (w_mag),
            .i_bypass (r_dbyp[ROOT_W-1]),
            .o_comp   (w_comp[g]),
            .o_renorm (w_renorm[g])
        );
    end

    assign o_prod_w           = w_comp[0];
    assign o_prod_x           = w_comp[1];
    assign o_prod_y           = w_comp[2];
    assign o_prod_z           = w_comp[3];
    assign o_was_renormalized = w_renorm[0];

`ifndef NO_ASSERTIONS
    // a waiting result blocks new input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output stalled");

    // renormalized w and x components stay within unit magnitude
    a_renorm_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_renormalized) |->
        (o_prod_w <= 18'sd65536 && o_prod_w >= -18'sd65536 &&
         o_prod_x <= 18'sd65536 && o_prod_x >= -18'sd65536))
        else $error("renormalized component out of range");

    // all lanes agree on the decision
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_renorm[0] == w_renorm[1] && w_renorm[0] == w_renorm[2] &&
                     w_renorm[0] == w_renorm[3]))
        else $error("lane decisions differ");

    // a stall freezes the occupancy of the pipeline
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

FILE: test/quaternion_product_normalize_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_normalize_tb
// Drives quaternion pairs through the normalizer and checks every product
// component and the renormalize flag against a local bit-exact predictor,
// under several tolerance settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module quaternion_product_normalize_tb import qpn_pkg::*; ();

    localparam int  CLK_HALF   = 4;
    localparam int  PIPE_DRAIN = LAT + 20;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        t_fix lw, lx, ly, lz, rw, rx, ry, rz;
    } t_pair;

    typedef struct packed {
        t_fix w, x, y, z;
        logic renorm;
    } t_quat_out;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [TOL_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    t_fix             i_left_w = '0, i_left_x = '0, i_left_y = '0, i_left_z = '0;
    t_fix             i_right_w = '0, i_right_x = '0, i_right_y = '0, i_right_z = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    t_fix             o_prod_w, o_prod_x, o_prod_y, o_prod_z;
    logic             o_was_renormalized;

    logic [TOL_W-1:0] tol_shadow = TOL_RESET;
    t_quat_out        expected_q[$];
    int               mismatches = 0;
    longint           cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               hold_off_cycles = 0;

    quaternion_product_normalize DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_left_w(i_left_w), .i_left_x(i_left_x),
        .i_left_y(i_left_y), .i_left_z(i_left_z),
        .i_right_w(i_right_w), .i_right_x(i_right_x),
        .i_right_y(i_right_y), .i_right_z(i_right_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_prod_w(o_prod_w), .o_prod_x(o_prod_x),
        .o_prod_y(o_prod_y), .o_prod_z(o_prod_z),
        .o_was_renormalized(o_was_renormalized)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint round_half_up(input longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic t_fix clamp_fix(input longint v);
        if (v > 131071) return FIX_MAX;
        if (v < -131072) return FIX_MIN;
        return t_fix'(v);
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_quat_out predict_normalized(input t_pair a,
                                                     input logic [TOL_W-1:0] tol_q);
        longint aw, ax, ay, az, bw, bx, by, bz;
        longint raw[4];
        longint p[4];
        longint unsigned sum, one, tol, diff, mag, n, q;
        longint comp[4];
        t_quat_out r;
        aw = a.lw; ax = a.lx; ay = a.ly; az = a.lz;
        bw = a.rw; bx = a.rx; by = a.ry; bz = a.rz;
        raw[0] = aw*bw - ax*bx - ay*by - az*bz;
        raw[1] = aw*bx + ax*bw + ay*bz - az*by;
        raw[2] = aw*by - ax*bz + ay*bw + az*bx;
        raw[3] = aw*bz + ax*by - ay*bx + az*bw;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            p[i] = round_half_up(raw[i]);
            sum += longint'(p[i] * p[i]);
        end
        one  = 64'd1 << (2 * FRAC_BITS);
        tol  = longint'(tol_q) << (2 * FRAC_BITS - TOL_W);
        diff = (sum > one) ? sum - one : one - sum;
        if (diff < tol || sum == 0) begin
            for (int i = 0; i < 4; i++) comp[i] = p[i];
            r.renorm = 1'b0;
        end else begin
            mag = isqrt(sum);
            for (int i = 0; i < 4; i++) begin
                n = longint'(p[i] < 0 ? -p[i] : p[i]) << FRAC_BITS;
                q = (2 * n + mag) / (2 * mag);
                comp[i] = (p[i] < 0) ? -longint'(q) : longint'(q);
            end
            r.renorm = 1'b1;
        end
        r.w = clamp_fix(comp[0]);
        r.x = clamp_fix(comp[1]);
        r.y = clamp_fix(comp[2]);
        r.z = clamp_fix(comp[3]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_quat_out e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                e = expected_q.pop_front();
                if (o_prod_w !== e.w)
                    report_mismatch($sformatf("w got %0d exp %0d", o_prod_w, e.w));
                if (o_prod_x !== e.x)
                    report_mismatch($sformatf("x got %0d exp %0d", o_prod_x, e.x));
                if (o_prod_y !== e.y)
                    report_mismatch($sformatf("y got %0d exp %0d", o_prod_y, e.y));
                if (o_prod_z !== e.z)
                    report_mismatch($sformatf("z got %0d exp %0d", o_prod_z, e.z));
                if (o_was_renormalized !== e.renorm)
                    report_mismatch($sformatf("flag got %0b exp %0b",
                                              o_was_renormalized, e.renorm));
            end
        end
    end

    // receiver ready: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pair(input t_pair a);
        // drop valid while idling between items
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_left_w  <= a.lw; i_left_x  <= a.lx; i_left_y  <= a.ly; i_left_z  <= a.lz;
        i_right_w <= a.rw; i_right_x <= a.rx; i_right_y <= a.ry; i_right_z <= a.rz;
        // hold until taken
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(predict_normalized(a, tol_shadow));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tol_shadow = v;
    endtask

    function automatic t_fix rand_fix(input int kind);
        case (kind)
            0: return t_fix'($urandom);
            1: return t_fix'($urandom_range(65536 + 4096) - 2048 - 32768);
            2: return ($urandom_range(1)) ? FIX_MAX : FIX_MIN;
            default: return t_fix'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    // quaternion pair, near-unit in modes 0 to 3 so the tolerance band is exercised
    function automatic t_pair rand_pair();
        t_pair a;
        int mode;
        mode = $urandom_range(9);
        if (mode < 4) begin
            a.lw = t_fix'(65536 - $urandom_range(8)); a.lx = t_fix'($urandom_range(8));
            a.ly = t_fix'(-$urandom_range(8));        a.lz = t_fix'($urandom_range(4));
            a.rw = t_fix'(65536 - $urandom_range(8)); a.rx = t_fix'(-$urandom_range(8));
            a.ry = t_fix'($urandom_range(8));         a.rz = t_fix'(-$urandom_range(4));
            if ($urandom_range(1)) a.lw = -a.lw;
            if ($urandom_range(1)) begin
                a.rx = a.rw; a.rw = t_fix'($urandom_range(8));
            end
        end else begin
            a.lw = rand_fix(mode % 4); a.lx = rand_fix($urandom_range(3));
            a.ly = rand_fix($urandom_range(3)); a.lz = rand_fix($urandom_range(3));
            a.rw = rand_fix(mode % 4); a.rx = rand_fix($urandom_range(3));
            a.ry = rand_fix($urandom_range(3)); a.rz = rand_fix($urandom_range(3));
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        t_pair a;
        // identity times identity: passes through
        a = '{65536, 0, 0, 0, 65536, 0, 0, 0};             send_pair(a);
        // zero sum passes zero through
        a = '0;                                             send_pair(a);
        a = '{1, 0, 0, 0, 0, 0, 0, 0};                      send_pair(a);
        // extremes that renormalize, and a tiny product that rounds to zero
        a = '{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN};
        send_pair(a);
        a = '{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX};
        send_pair(a);
        a = '{FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX};
        send_pair(a);
        a = '{FIX_MIN, 0, 0, 0, FIX_MIN, 0, 0, 0};          send_pair(a);
        a = '{-1, -1, -1, -1, -1, -1, -1, -1};              send_pair(a);
        // basis products i*j, j*k, k*i
        a = '{0, 65536, 0, 0, 0, 0, 65536, 0};              send_pair(a);
        a = '{0, 0, 65536, 0, 0, 0, 0, 65536};              send_pair(a);
        a = '{0, 0, 0, 65536, 0, 65536, 0, 0};              send_pair(a);
        // slightly off unit: inside and outside the default tolerance
        a = '{65537, 0, 0, 0, 65536, 0, 0, 0};              send_pair(a);
        a = '{65600, 0, 0, 0, 65536, 0, 0, 0};              send_pair(a);
        a = '{32768, 0, 0, 0, 32768, 0, 0, 0};              send_pair(a);
        a = '{-46341, 46341, 0, 0, 65536, 0, 0, 0};         send_pair(a);
        // rounding ties on the product
        a = '{32768, 0, 0, 0, 1, 0, 0, 0};                  send_pair(a);
        a = '{-32768, 0, 0, 0, 1, 0, 0, 0};                 send_pair(a);
        a = '{3, 5, -7, 11, 13, -17, 19, -23};              send_pair(a);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_pair(rand_pair());
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 3 * LAT + 40;
        test_random(150);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(250);

        write_tolerance(16'd0);
        test_directed();
        send_idle_pct = 86;
        test_random(250);

        write_tolerance(16'hFFFF);
        send_idle_pct = 0; recv_stall_pct = 86;
        test_directed();
        test_random(250);

        write_tolerance(16'd300);
        send_idle_pct = 21; recv_stall_pct = 21;
        test_random(350);

        write_tolerance(TOL_RESET);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(350);
        test_backpressure();

        write_tolerance(16'h8000);
        send_idle_pct = 21; recv_stall_pct = 21;
        test_random(250);

        wait_drained();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
